// ----- hdl/can_frame_serial_deframer_unit_defines.svh -----
// assertion macros for the serial can deframer
// no dependencies; included by the modules that carry assertions
`ifndef CAN_FRAME_SERIAL_DEFRAMER_UNIT_DEFINES_SVH
`define CAN_FRAME_SERIAL_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfsd assertion failed");

// next-cycle implication, disabled in reset
`define CFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfsd assertion failed");

`endif

// ----- hdl/cfsd_pkg.sv -----
// shared widths, limits and register indexes of the serial can deframer
// no dependencies
`default_nettype none

package cfsd_pkg;

   // field widths
   localparam int RX_W       = 8;
   localparam int ID_W       = 16;
   localparam int RTR_W      = 8;
   localparam int LEN_W      = 4;
   localparam int MSG_DATA_W = 64;
   localparam int RSP_TDATA_W = 96;   // 92 bits of fields, padded to whole bytes

   // frame limits
   localparam int MAX_PAYLOAD_DEF = 8;
   localparam int LEN_MIN         = 3;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 1'd1;

endpackage

`default_nettype wire

// ----- hdl/can_frame_serial_deframer_unit.sv -----
// serial can deframer: sync hunt, length check and message assembly
// depends on cfsd_pkg and can_frame_serial_deframer_unit_defines.svh
// throughput: one byte per cycle; req_tready drops only while a message waits unaccepted
// a message turns valid in the cycle after its last byte beat is accepted,
// since the single byte-wide state update is combinational and feeds the output register
// reset (synchronous, active high): hunting for sync, sync values zero, no message held
`default_nettype none

module can_frame_serial_deframer_unit #(
   parameter int MAX_PAYLOAD = cfsd_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // receive byte channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cfsd_pkg::RX_W-1:0]         req_tdata,   // rx_byte[7:0]
   // message channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // msg_id[15:0], msg_rtr[23:16], msg_len[27:24], msg_data[91:28], zero[95:92]
   output logic [cfsd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // configuration writes
   input  wire logic                              csr_wr_en,
   input  wire logic [cfsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cfsd_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

`include "can_frame_serial_deframer_unit_defines.svh"

   localparam int DATA_W  = MAX_PAYLOAD * 8;
   localparam int LEN_MAX = cfsd_pkg::LEN_MIN + MAX_PAYLOAD;
   localparam int PAD_W   = cfsd_pkg::RSP_TDATA_W - cfsd_pkg::ID_W - cfsd_pkg::RTR_W
                            - cfsd_pkg::LEN_W - cfsd_pkg::MSG_DATA_W;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SYNC1,
      PH_LENGTH,
      PH_BODY
   } phase_type;

   // state
   phase_type                      phase_ff, phase_in;
   logic [cfsd_pkg::LEN_W-1:0]     frame_len_ff, frame_len_in;
   logic [cfsd_pkg::LEN_W-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [cfsd_pkg::ID_W-1:0]      id_ff, id_in;
   logic [cfsd_pkg::RTR_W-1:0]     rtr_ff, rtr_in;
   logic [DATA_W-1:0]              data_ff, data_in;
   logic [cfsd_pkg::RX_W-1:0]      sync_first_ff, sync_second_ff;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cfsd_pkg::ID_W-1:0]      rsp_id_ff;
   logic [cfsd_pkg::RTR_W-1:0]     rsp_rtr_ff;
   logic [cfsd_pkg::LEN_W-1:0]     rsp_len_ff;
   logic [cfsd_pkg::MSG_DATA_W-1:0] rsp_data_ff;

   logic                           accept;
   logic                           emit;
   logic [cfsd_pkg::LEN_W-1:0]     cnt_next;
   logic [cfsd_pkg::RX_W-1:0]      rx_byte;

   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cnt_next   = byte_cnt_ff + 4'd1;

   // per-byte phase update and body collection
   always_comb begin
      phase_in     = phase_ff;
      frame_len_in = frame_len_ff;
      byte_cnt_in  = byte_cnt_ff;
      id_in        = id_ff;
      rtr_in       = rtr_ff;
      data_in      = data_ff;
      emit         = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == sync_first_ff) phase_in = PH_SYNC1;
            end
            PH_SYNC1: begin
               phase_in = (rx_byte == sync_second_ff) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH: begin
               if (rx_byte < 8'(cfsd_pkg::LEN_MIN) || rx_byte > 8'(LEN_MAX)) begin
                  phase_in = PH_HUNT;
               end else begin
                  frame_len_in = rx_byte[cfsd_pkg::LEN_W-1:0];
                  byte_cnt_in  = '0;
                  id_in        = '0;
                  rtr_in       = '0;
                  data_in      = '0;
                  phase_in     = PH_BODY;
               end
            end
            PH_BODY: begin
               // identifier low, identifier high, rtr, then data lanes
               if (byte_cnt_ff == 4'd0) id_in[7:0]  = rx_byte;
               if (byte_cnt_ff == 4'd1) id_in[15:8] = rx_byte;
               if (byte_cnt_ff == 4'd2) rtr_in      = rx_byte;
               for (int i = 0; i < MAX_PAYLOAD; i++) begin
                  if (byte_cnt_ff == 4'(cfsd_pkg::LEN_MIN + i)) data_in[i*8 +: 8] = rx_byte;
               end
               byte_cnt_in = cnt_next;
               if (cnt_next >= frame_len_ff) begin
                  emit        = 1'b1;
                  byte_cnt_in = '0;
                  phase_in    = PH_HUNT;
               end
            end
         endcase
      end
   end

   // output valid: set by a finished frame, cleared when the beat is taken
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         byte_cnt_ff    <= '0;
         frame_len_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         byte_cnt_ff  <= byte_cnt_in;
         frame_len_ff <= frame_len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               cfsd_pkg::CSR_SYNC_FIRST:  sync_first_ff  <= csr_wr_data;
               cfsd_pkg::CSR_SYNC_SECOND: sync_second_ff <= csr_wr_data;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      rtr_ff  <= rtr_in;
      data_ff <= data_in;
      if (emit) begin
         rsp_id_ff   <= id_in;
         rsp_rtr_ff  <= rtr_in;
         rsp_len_ff  <= frame_len_ff - 4'(cfsd_pkg::LEN_MIN);
         rsp_data_ff <= 64'(data_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff, rsp_len_ff, rsp_rtr_ff, rsp_id_ff};

   // checks
   `CFSD_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_tready, rsp_valid_ff)
   `CFSD_ASSERT_NOW(a_len_in_range, clock, reset, rsp_valid_ff,
                    rsp_len_ff <= 4'(MAX_PAYLOAD))
   `CFSD_ASSERT_NOW(a_unused_bytes_zero, clock, reset, rsp_valid_ff,
                    (rsp_data_ff >> {rsp_len_ff, 3'b000}) == 64'd0)
   `CFSD_ASSERT_NEXT(a_emit_from_body, clock, reset, emit,
                     rsp_valid_ff && phase_ff == PH_HUNT && byte_cnt_ff == 4'd0)

endmodule

`default_nettype wire

// ----- sim/can_frame_serial_deframer_unit_test.sv -----
`timescale 1ns / 100ps
// testbench for can_frame_serial_deframer_unit: streams sync-framed serial bytes and checks
// every decoded message against a behavioral deframer kept in this file
// depends on cfsd_pkg and the deframer rtl

module can_frame_serial_deframer_unit_test;

   localparam int LEN_MAX      = cfsd_pkg::LEN_MIN + cfsd_pkg::MAX_PAYLOAD_DEF;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES  = 180;
   localparam int IDLE_PCT     = 34;

   typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, TAKE_LENGTH, TAKE_BODY} rx_phase_type;

   typedef struct packed {
      logic [cfsd_pkg::ID_W-1:0]       id;
      logic [cfsd_pkg::RTR_W-1:0]      rtr;
      logic [cfsd_pkg::LEN_W-1:0]      len;
      logic [cfsd_pkg::MSG_DATA_W-1:0] data;
   } can_msg_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [cfsd_pkg::RX_W-1:0]        req_tdata   = '0;   // rx_byte[7:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   // msg_id[15:0], msg_rtr[23:16], msg_len[27:24], msg_data[91:28], zero[95:92]
   logic [cfsd_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             csr_wr_en   = 1'b0;
   logic [cfsd_pkg::CSR_IDX_W-1:0]   csr_index   = cfsd_pkg::CSR_SYNC_FIRST;
   logic [cfsd_pkg::CSR_DATA_W-1:0]  csr_wr_data = '0;

   // stimulus side
   logic [cfsd_pkg::RX_W-1:0] rx_bytes_pending[$];
   int              send_idle_pct = IDLE_PCT;
   int              recv_idle_pct = IDLE_PCT;
   logic [7:0]      stim_first    = 8'h00;
   logic [7:0]      stim_second   = 8'h00;

   // behavioral deframer state
   logic [7:0]      sync_first_cfg  = 8'h00;
   logic [7:0]      sync_second_cfg = 8'h00;
   rx_phase_type    rx_phase        = HUNT_FIRST;
   logic [3:0]      frame_len       = '0;
   logic [3:0]      body_count      = '0;
   logic [15:0]     id_acc          = '0;
   logic [7:0]      rtr_acc         = '0;
   logic [63:0]     data_acc        = '0;
   can_msg_type     expected_msgs[$];

   int mismatch_count = 0;
   int stall_cycles   = 0;

   can_frame_serial_deframer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // clock and the single reset pulse
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // advance the deframer by one accepted byte, queue a message when a frame closes
   task automatic deframe_byte(input logic [7:0] rx);
      int slot;
      case (rx_phase)
         HUNT_FIRST: begin
            if (rx == sync_first_cfg) rx_phase = HUNT_SECOND;
         end
         HUNT_SECOND: begin
            rx_phase = (rx == sync_second_cfg) ? TAKE_LENGTH : HUNT_FIRST;
         end
         TAKE_LENGTH: begin
            if (rx < cfsd_pkg::LEN_MIN || rx > LEN_MAX) begin
               rx_phase = HUNT_FIRST;
            end else begin
               frame_len  = rx[3:0];
               body_count = '0;
               id_acc     = '0;
               rtr_acc    = '0;
               data_acc   = '0;
               rx_phase   = TAKE_BODY;
            end
         end
         TAKE_BODY: begin
            case (body_count)
               4'd0: id_acc[7:0]  = rx;
               4'd1: id_acc[15:8] = rx;
               4'd2: rtr_acc      = rx;
               default: begin
                  slot = (int'(body_count) - 3) & 7;
                  data_acc = data_acc | (64'(rx) << (8 * slot));
               end
            endcase
            body_count = body_count + 4'd1;
            if (body_count >= frame_len) begin
               expected_msgs.push_back('{id_acc, rtr_acc, frame_len - 4'd3, data_acc});
               rx_phase   = HUNT_FIRST;
               body_count = '0;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // byte driver: a new beat only once the previous one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (rx_bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= rx_bytes_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // message sink back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor: register mirror, message check, then prediction of the accepted byte
   always @(posedge clock) begin
      can_msg_type want;
      if (reset) begin
         sync_first_cfg  = 8'h00;
         sync_second_cfg = 8'h00;
         rx_phase        = HUNT_FIRST;
         frame_len       = '0;
         body_count      = '0;
         id_acc          = '0;
         rtr_acc         = '0;
         data_acc        = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cfsd_pkg::CSR_SYNC_FIRST:  sync_first_cfg  = csr_wr_data;
               cfsd_pkg::CSR_SYNC_SECOND: sync_second_cfg = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_msgs.size() == 0) begin
               $display("%0t: unexpected message, expected none actual %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_msgs.pop_front();
               check_field("msg_id",   64'(want.id),   64'(rsp_tdata[15:0]));
               check_field("msg_rtr",  64'(want.rtr),  64'(rsp_tdata[23:16]));
               check_field("msg_len",  64'(want.len),  64'(rsp_tdata[27:24]));
               check_field("msg_data", want.data,      rsp_tdata[91:28]);
            end
         end
         if (req_tvalid && req_tready) deframe_byte(req_tdata);
      end
   end

   // watchdog on cycles with no beat and no register write
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("can_frame_serial_deframer_unit_test: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= cfsd_pkg::CSR_SYNC_FIRST;
      csr_wr_data <= first;
      @(posedge clock);
      csr_index   <= cfsd_pkg::CSR_SYNC_SECOND;
      csr_wr_data <= second;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      stim_first  = first;
      stim_second = second;
   endtask

   task automatic queue_frame(input logic [7:0] len, input logic [15:0] id,
                              input logic [7:0] rtr, input logic [63:0] payload);
      rx_bytes_pending.push_back(stim_first);
      rx_bytes_pending.push_back(stim_second);
      rx_bytes_pending.push_back(len);
      rx_bytes_pending.push_back(id[7:0]);
      rx_bytes_pending.push_back(id[15:8]);
      rx_bytes_pending.push_back(rtr);
      for (int i = 0; i < int'(len) - 3; i++) rx_bytes_pending.push_back(payload[8*i +: 8]);
   endtask

   // mostly good frames, some broken headers and bad lengths, a little line noise
   task automatic queue_random_bytes(input int target);
      int         pick;
      logic [7:0] wrong;
      while (rx_bytes_pending.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            queue_frame(8'($urandom_range(cfsd_pkg::LEN_MIN, LEN_MAX)), 16'($urandom),
                        8'($urandom), {$urandom, $urandom});
         end else if (pick < 83) begin
            do wrong = 8'($urandom); while (wrong == stim_second);
            rx_bytes_pending.push_back(stim_first);
            rx_bytes_pending.push_back(wrong);
         end else if (pick < 91) begin
            rx_bytes_pending.push_back(stim_first);
            rx_bytes_pending.push_back(stim_second);
            if ($urandom_range(0, 1) == 0)
               rx_bytes_pending.push_back(8'($urandom_range(0, cfsd_pkg::LEN_MIN - 1)));
            else
               rx_bytes_pending.push_back(8'($urandom_range(LEN_MAX + 1, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) rx_bytes_pending.push_back(8'($urandom));
         end
      end
   endtask

   // hold off until every byte is taken and every message has come out
   task automatic wait_drained();
      while (rx_bytes_pending.size() != 0 || req_tvalid || expected_msgs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus sequence
   initial begin
      wait (!reset);
      write_sync(8'hAA, 8'h55);

      // wrong second header equal to the first one, then a byte that must be ignored
      rx_bytes_pending.push_back(8'hAA);
      rx_bytes_pending.push_back(8'hAA);
      rx_bytes_pending.push_back(8'h55);
      // length zero, frame dropped
      rx_bytes_pending.push_back(8'hAA);
      rx_bytes_pending.push_back(8'h55);
      rx_bytes_pending.push_back(8'h00);
      // shortest frame, no data bytes
      queue_frame(8'd3, 16'h0000, 8'h00, 64'h0);
      // longest frame with header values inside the body
      queue_frame(8'd11, 16'h55AA, 8'hFF, 64'hFE7F_0180_55AA_00FF);
      wait_drained();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: write_sync(8'h00, 8'hFF);
            1: write_sync(8'hFF, 8'h00);
            2: write_sync(8'h00, 8'h00);
            3: write_sync(8'hFF, 8'hFF);
            default: write_sync(8'($urandom), 8'($urandom));
         endcase
         // one phase runs with both sides streaming flat out
         send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
         recv_idle_pct = (p == 2) ? 0 : IDLE_PCT;
         queue_random_bytes(PHASE_BYTES);
         wait_drained();
      end

      if (mismatch_count == 0 && expected_msgs.size() == 0) begin
         $display("can_frame_serial_deframer_unit_test: done, clean");
      end else begin
         $display("can_frame_serial_deframer_unit_test: done, errors");
      end
      $finish;
   end

endmodule
